/* design/patch_majority_vote_label_core_assert.svh */
// Assertion macros used by the checker file.
// Each macro takes a label, a condition and a consequence, clocked on i_clk.
`ifndef PATCH_MAJORITY_VOTE_LABEL_CORE_ASSERT_SVH
`define PATCH_MAJORITY_VOTE_LABEL_CORE_ASSERT_SVH

// The consequence holds in the same cycle as the condition.
`define PMVL_ASSERT_SAME(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("pmvl assertion failed");

// The consequence holds in the cycle after the condition.
`define PMVL_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("pmvl assertion failed");

`endif

/* design/pmvl_pkg.sv */
package pmvl_pkg;

    localparam int MAX_CLASSES      = 16;
    localparam int MAX_PATCH_PIXELS = 4096;
    localparam int NUM_CNT          = MAX_CLASSES + 1;
    localparam int CNT_W            = $clog2(MAX_PATCH_PIXELS + 1);
    localparam int LABEL_W          = $clog2(MAX_CLASSES + 1);
    localparam int BITS_W           = 16;
    localparam int CFG_W            = 5;
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;
    localparam int TREE_LVLS        = $clog2(MAX_CLASSES);

    localparam logic [CFG_W-1:0] CLASS_COUNT_RESET = CFG_W'(16);

    // Word index of the class count register.
    localparam logic REG_CLASS_COUNT = 1'b0;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [NUM_CNT-1:0][CNT_W-1:0] t_cnt_arr;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        t_cnt               count;
        logic               truthed;
        logic               competing;
    } t_vote;

    function automatic t_cnt sat_inc(input t_cnt c);
        return (&c) ? c : t_cnt'(c + 1'b1);
    endfunction

endpackage

/* design/pmvl_vote_tree.sv */
module pmvl_vote_tree (
    input  pmvl_pkg::t_cnt_arr                i_counts,
    input  logic [pmvl_pkg::CFG_W-1:0]        i_active,
    output pmvl_pkg::t_vote                   o_vote
);

    pmvl_pkg::t_cnt               val [pmvl_pkg::MAX_CLASSES];
    logic [pmvl_pkg::LABEL_W-1:0] idx [pmvl_pkg::MAX_CLASSES];
    logic                         tie [pmvl_pkg::MAX_CLASSES];
    pmvl_pkg::t_cnt               best;
    logic                         any_seen;

    // Pairwise tree; on equal counts the lower class wins and the tie is remembered.
    always_comb begin
        for (int i = 0; i < pmvl_pkg::MAX_CLASSES; i++) begin
            val[i] = (pmvl_pkg::CFG_W'(i) < i_active) ? i_counts[i+1] : '0;
            idx[i] = pmvl_pkg::LABEL_W'(i + 1);
            tie[i] = 1'b0;
        end
        for (int l = 0; l < pmvl_pkg::TREE_LVLS; l++) begin
            for (int i = 0; i < (pmvl_pkg::MAX_CLASSES >> (l + 1)); i++) begin
                if (val[2*i+1] > val[2*i]) begin
                    val[i] = val[2*i+1];
                    idx[i] = idx[2*i+1];
                    tie[i] = tie[2*i+1];
                end else if (val[2*i+1] == val[2*i]) begin
                    val[i] = val[2*i];
                    idx[i] = idx[2*i];
                    tie[i] = 1'b1;
                end else begin
                    val[i] = val[2*i];
                    idx[i] = idx[2*i];
                    tie[i] = tie[2*i];
                end
            end
        end
        best     = val[0];
        any_seen = |best;
    end

    assign o_vote.label     = any_seen ? idx[0] : '0;
    assign o_vote.count     = best;
    assign o_vote.truthed   = any_seen;
    assign o_vote.competing = any_seen & (tie[0] | (i_counts[0] == best));

endmodule

/* design/patch_majority_vote_label_core.sv */
// Channel   Direction  Handshake                   Payload
// config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
// pixel     in         i_in_valid / o_in_ready     i_class_bits, i_last_pixel
// label     out        o_out_valid / i_out_ready   o_label, o_winner_count,
//                                                  o_truthed, o_competing
//
// One pixel is taken per cycle unless a last pixel is held; counters update from r_in_bits.
// A label appears after the last pixel passes the input, snapshot and output registers.
// The compare tree sits between a counter snapshot register and the output register.
// Reset clears the counters and sets the class count to 16.
// A stalled label holds back only a last pixel, and only once the snapshot stage is also full.
module patch_majority_vote_label_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pmvl_pkg::ADDR_W-1:0]       paddr,
    input  logic [pmvl_pkg::DATA_W-1:0]       pwdata,
    output logic [pmvl_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pmvl_pkg::BITS_W-1:0]       i_class_bits,
    input  logic                              i_last_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pmvl_pkg::LABEL_W-1:0]      o_label,
    output logic [pmvl_pkg::CNT_W-1:0]        o_winner_count,
    output logic                              o_truthed,
    output logic                              o_competing
);

    logic [pmvl_pkg::CFG_W-1:0]  r_class_count;
    logic [pmvl_pkg::CFG_W-1:0]  active;
    logic                        r_in_vld;
    logic [pmvl_pkg::BITS_W-1:0] r_in_bits;
    logic                        r_in_last;
    pmvl_pkg::t_cnt_arr          r_cnt;
    pmvl_pkg::t_cnt_arr          n_cnt;
    pmvl_pkg::t_cnt_arr          r_snap;
    logic                        r_snap_vld;
    pmvl_pkg::t_vote             r_out;
    logic                        r_out_vld;
    pmvl_pkg::t_vote             vote;
    logic [pmvl_pkg::MAX_CLASSES-1:0] hit;
    logic                        out_free;
    logic                        snap_free;
    logic                        snap_go;
    logic                        s0_go;
    logic                        in_ready;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == pmvl_pkg::REG_CLASS_COUNT);
    assign prdata = (paddr[2] == pmvl_pkg::REG_CLASS_COUNT)
                  ? pmvl_pkg::DATA_W'(r_class_count) : '0;

    assign active = (r_class_count > pmvl_pkg::CFG_W'(pmvl_pkg::MAX_CLASSES))
                  ? pmvl_pkg::CFG_W'(pmvl_pkg::MAX_CLASSES) : r_class_count;

    assign out_free  = ~r_out_vld | i_out_ready;
    assign snap_go   = r_snap_vld & out_free;
    assign snap_free = ~r_snap_vld | out_free;
    assign s0_go     = r_in_vld & (~r_in_last | snap_free);
    assign in_ready  = ~r_in_vld | s0_go;

    always_comb begin
        for (int k = 0; k < pmvl_pkg::MAX_CLASSES; k++) begin
            hit[k]        = r_in_bits[k] & (pmvl_pkg::CFG_W'(k) < active);
            n_cnt[k+1]    = hit[k] ? pmvl_pkg::sat_inc(r_cnt[k+1]) : r_cnt[k+1];
        end
        n_cnt[0] = (|hit) ? r_cnt[0] : pmvl_pkg::sat_inc(r_cnt[0]);
    end

    pmvl_vote_tree u_tree (
        .i_counts (r_snap),
        .i_active (active),
        .o_vote   (vote)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count <= pmvl_pkg::CLASS_COUNT_RESET;
            r_in_vld      <= 1'b0;
            r_snap_vld    <= 1'b0;
            r_out_vld     <= 1'b0;
            r_cnt         <= '0;
        end else begin
            if (cfg_wr) begin
                r_class_count <= pwdata[pmvl_pkg::CFG_W-1:0];
            end
            if (in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (s0_go) begin
                r_cnt <= r_in_last ? '0 : n_cnt;
            end
            if (s0_go && r_in_last) begin
                r_snap_vld <= 1'b1;
            end else if (snap_go) begin
                r_snap_vld <= 1'b0;
            end
            if (snap_go) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in_bits <= i_class_bits;
            r_in_last <= i_last_pixel;
        end
        if (s0_go && r_in_last) begin
            r_snap <= n_cnt;
        end
        if (snap_go) begin
            r_out <= vote;
        end
    end

    assign o_in_ready     = in_ready;
    assign o_out_valid    = r_out_vld;
    assign o_label        = r_out.label;
    assign o_winner_count = r_out.count;
    assign o_truthed      = r_out.truthed;
    assign o_competing    = r_out.competing;

endmodule

/* design/pmvl_checker.sv */
`include "patch_majority_vote_label_core_assert.svh"

module pmvl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [pmvl_pkg::LABEL_W-1:0]  o_label,
    input logic [pmvl_pkg::CNT_W-1:0]    o_winner_count,
    input logic                          o_truthed,
    input logic                          o_competing
);

    `PMVL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_label) && $stable(o_winner_count) && $stable(o_competing))
    `PMVL_ASSERT_SAME(a_untruthed_zero, o_out_valid && !o_truthed, o_label == '0 && o_winner_count == '0 && !o_competing)
    `PMVL_ASSERT_SAME(a_truthed_count, o_out_valid && o_truthed, o_winner_count != '0)
    `PMVL_ASSERT_SAME(a_label_range, o_out_valid && o_truthed, o_label != '0 && o_label <= pmvl_pkg::LABEL_W'(pmvl_pkg::MAX_CLASSES))

endmodule

bind patch_majority_vote_label_core pmvl_checker u_pmvl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_label        (o_label),
    .o_winner_count (o_winner_count),
    .o_truthed      (o_truthed),
    .o_competing    (o_competing)
);

/* tb/patch_majority_vote_label_core_tb.sv */
`timescale 1ns / 100ps

module patch_majority_vote_label_core_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTING_PIXELS = 67;
    localparam logic [pmvl_pkg::ADDR_W-1:0] CLASS_COUNT_ADDR =
        pmvl_pkg::ADDR_W'(4 * int'(pmvl_pkg::REG_CLASS_COUNT));

    class label_vote_model;
        pmvl_pkg::t_cnt             class_tallies[pmvl_pkg::NUM_CNT];
        logic [pmvl_pkg::CFG_W-1:0] class_count;
        pmvl_pkg::t_vote            expected_labels[$];
        int                         errors;
        int                         labels_checked;
        int                         pixels_seen;

        function new();
            class_count = pmvl_pkg::CLASS_COUNT_RESET;
            clear_tallies();
        endfunction

        function void clear_tallies();
            foreach (class_tallies[i]) class_tallies[i] = '0;
        endfunction

        function int active_classes();
            int n;
            n = int'(class_count);
            if (n > pmvl_pkg::MAX_CLASSES) n = pmvl_pkg::MAX_CLASSES;
            if (n > pmvl_pkg::BITS_W) n = pmvl_pkg::BITS_W;
            return n;
        endfunction

        function void bump(int idx);
            if (class_tallies[idx] != '1) class_tallies[idx] = class_tallies[idx] + 1'b1;
        endfunction

        function int pending();
            return expected_labels.size();
        endfunction

        function void note_pixel(logic [pmvl_pkg::BITS_W-1:0] bits, logic last);
            int              n;
            bit              any;
            pmvl_pkg::t_cnt  best;
            int              winner;
            int              ties;
            pmvl_pkg::t_vote v;
            n = active_classes();
            any = 1'b0;
            pixels_seen++;
            for (int k = 0; k < n; k++) begin
                if (bits[k]) begin
                    any = 1'b1;
                    bump(k + 1);
                end
            end
            if (!any) bump(0);
            if (!last) return;
            best = '0;
            winner = 0;
            for (int k = 0; k < n; k++) begin
                if (class_tallies[k + 1] > best) begin
                    best = class_tallies[k + 1];
                    winner = k + 1;
                end
            end
            ties = 0;
            if (best != 0) begin
                for (int k = 0; k <= n; k++) begin
                    if (class_tallies[k] == best) ties++;
                end
            end
            v.label = pmvl_pkg::LABEL_W'(winner);
            v.count = best;
            v.truthed = (best != 0);
            v.competing = (best != 0) && (ties > 1);
            expected_labels.push_back(v);
            clear_tallies();
        endfunction

        function void check_label(logic [pmvl_pkg::LABEL_W-1:0] label, pmvl_pkg::t_cnt count,
                                  logic truthed, logic competing);
            pmvl_pkg::t_vote v;
            if (expected_labels.size() == 0) begin
                $error("Unexpected label transfer: label %0d, winner_count %0d", label, count);
                errors++;
                return;
            end
            v = expected_labels.pop_front();
            labels_checked++;
            if (label !== v.label) begin
                $error("label: expected %0d, actual %0d", v.label, label);
                errors++;
            end
            if (count !== v.count) begin
                $error("winner_count: expected %0d, actual %0d", v.count, count);
                errors++;
            end
            if (truthed !== v.truthed) begin
                $error("truthed: expected %0d, actual %0d", v.truthed, truthed);
                errors++;
            end
            if (competing !== v.competing) begin
                $error("competing: expected %0d, actual %0d", v.competing, competing);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [pmvl_pkg::ADDR_W-1:0]  paddr = '0;
    logic [pmvl_pkg::DATA_W-1:0]  pwdata = '0;
    logic [pmvl_pkg::DATA_W-1:0]  prdata;
    logic                         pready;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [pmvl_pkg::BITS_W-1:0]  i_class_bits = '0;
    logic                         i_last_pixel = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [pmvl_pkg::LABEL_W-1:0] o_label;
    logic [pmvl_pkg::CNT_W-1:0]   o_winner_count;
    logic                         o_truthed;
    logic                         o_competing;

    label_vote_model votes;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int random_pixels = 0;
    int settings_used = 0;

    patch_majority_vote_label_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_class_bits   (i_class_bits),
        .i_last_pixel   (i_last_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_label        (o_label),
        .o_winner_count (o_winner_count),
        .o_truthed      (o_truthed),
        .o_competing    (o_competing)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) votes.note_pixel(i_class_bits, i_last_pixel);
            if (o_out_valid && i_out_ready) begin
                votes.check_label(o_label, o_winner_count, o_truthed, o_competing);
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_pixel(input logic [pmvl_pkg::BITS_W-1:0] bits, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_class_bits <= bits;
        i_last_pixel <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain_labels();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (votes.pending() > 0) @(posedge i_clk);
    endtask

    task automatic write_class_count(input int value);
        drain_labels();
        repeat (4) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CLASS_COUNT_ADDR;
        pwdata <= pmvl_pkg::DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        votes.class_count = pmvl_pkg::CFG_W'(value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== pmvl_pkg::DATA_W'(votes.class_count)) begin
            $error("class_count readback: expected %0d, actual %0d", votes.class_count, prdata);
            votes.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [pmvl_pkg::BITS_W-1:0] random_pixel(input int n);
        logic [pmvl_pkg::BITS_W:0] low_mask;
        low_mask = (17'd1 << n) - 17'd1;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                if (n == 0) return '0;
                return pmvl_pkg::BITS_W'(1) << $urandom_range(n - 1);
            end
            6: return '0;
            7: return pmvl_pkg::BITS_W'($urandom);
            8: return pmvl_pkg::BITS_W'($urandom) & ~low_mask[pmvl_pkg::BITS_W-1:0];
            default: begin
                if (n == 0) return pmvl_pkg::BITS_W'($urandom);
                return (pmvl_pkg::BITS_W'(1) << $urandom_range(n - 1)) |
                       (pmvl_pkg::BITS_W'(1) << $urandom_range(n - 1));
            end
        endcase
    endfunction

    task automatic run_patch();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(16, 60) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            send_pixel(random_pixel(votes.active_classes()), i == len - 1);
            random_pixels++;
        end
    endtask

    initial begin
        int phase_counts[3][4] = '{'{16, 5, 1, 31}, '{0, 9, 17, -1}, '{16, 2, -1, 12}};
        int target;
        int value;
        votes = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pixel(16'h0000, 1'b1);
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'h8000, 1'b1);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'h0002, 1'b0);
        send_pixel(16'h0002, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0004, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0004, 1'b1);
        send_pixel(16'h5555, 1'b0);
        send_pixel(16'hAAAA, 1'b0);
        send_pixel(16'h0000, 1'b1);
        write_class_count(0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0001, 1'b1);
        write_class_count(1);
        send_pixel(16'hFFFE, 1'b0);
        send_pixel(16'h0001, 1'b1);
        write_class_count(31);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'hC000, 1'b1);

        target = 0;
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 24 : (p == 1) ? 65 : 0;
            recv_stall_pct = (p == 0) ? 65 : (p == 1) ? 24 : 0;
            for (int s = 0; s < 4; s++) begin
                value = phase_counts[p][s];
                if (value < 0) value = $urandom_range(31);
                write_class_count(value);
                target += SETTING_PIXELS;
                while (random_pixels < target) begin
                    run_patch();
                    if ($urandom_range(39) == 0) drain_labels();
                end
            end
        end

        drain_labels();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d pixels and %0d labels over %0d class count settings,",
                 votes.pixels_seen, votes.labels_checked, settings_used);
        $display("including empty patches, ties with the null class and oversized class counts.");
        if (votes.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
